/* sv/bilinear_image_upscaler_core_defines.svh */
// Assertion helpers for the upscaler RTL.
`ifndef BILINEAR_IMAGE_UPSCALER_CORE_DEFINES_SVH
`define BILINEAR_IMAGE_UPSCALER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define UPSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("upscaler assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define UPSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("upscaler assertion failed");

`endif

/* sv/upsc_pkg.sv */
package upsc_pkg;

  localparam int unsigned DimW      = 13;
  localparam int unsigned CoordW    = 12;
  localparam int unsigned IdxW      = 17;
  localparam int unsigned RgbW      = 24;
  localparam int unsigned PixW      = 32;
  localparam int unsigned FW        = 8;
  localparam int unsigned SrcCoordW = 10;
  localparam int unsigned NumW      = 24;
  localparam int unsigned QiW       = 11;
  localparam int unsigned FracShift = 15;
  localparam int unsigned QW        = QiW + FracShift;
  localparam int unsigned RemW      = DimW + 1;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned DivStages = QW / StepsPerStage;

  localparam logic [DimW-1:0] DstWidthRst  = 13'd640;
  localparam logic [DimW-1:0] DstHeightRst = 13'd480;
  localparam logic [QW-1:0]   HalfPos      = 26'd32768;
  localparam logic [7:0]      AlphaOpaque  = 8'hFF;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic CFG_DST_WIDTH  = 1'b0;
  localparam logic CFG_DST_HEIGHT = 1'b1;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [QW-1:0]   quo;
    logic [QW-1:0]   bits;
    logic [DimW-1:0] div;
    logic            sat;
  } lane_t;

  typedef struct packed {
    logic                 is_rd;
    lane_t                lx;
    lane_t                ly;
    logic                 wr_ok;
    logic [SrcCoordW-1:0] wx;
    logic [SrcCoordW-1:0] wy;
    logic [RgbW-1:0]      pix;
  } dtok_t;

  function automatic logic [RgbW-1:0] blend_rgb(input logic [RgbW-1:0] a,
                                                input logic [RgbW-1:0] b,
                                                input logic [FW-1:0] f);
    logic [RgbW-1:0] res;
    logic [16:0]     s;
    res = '0;
    for (int c = 0; c < 3; c++) begin
      s = 17'(a[c*8 +: 8]) * 17'(9'd256 - 9'(f)) + 17'(b[c*8 +: 8]) * 17'(f);
      res[c*8 +: 8] = s[15:8];
    end
    return res;
  endfunction

endpackage

/* sv/upsc_intf.sv */
interface upsc_in_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic [upsc_pkg::IdxW-1:0]       src_index;
  logic [upsc_pkg::RgbW-1:0]       src_pixel;
  logic [upsc_pkg::CoordW-1:0]     dst_x;
  logic [upsc_pkg::CoordW-1:0]     dst_y;
  modport source(output valid, req_type, src_index, src_pixel, dst_x, dst_y, input ready);
  modport sink(input valid, req_type, src_index, src_pixel, dst_x, dst_y, output ready);
endinterface

interface upsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [upsc_pkg::PixW-1:0]   out_pixel;
  modport source(output valid, out_pixel, input ready);
  modport sink(input valid, out_pixel, output ready);
endinterface

/* sv/upsc_div_stage.sv */
module upsc_div_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_v,
  input  upsc_pkg::dtok_t   up_tok,
  output logic              up_rdy,
  output logic              dn_v,
  output upsc_pkg::dtok_t   dn_tok,
  input  logic              dn_rdy
);

  logic            v_r;
  upsc_pkg::dtok_t tok_r;
  upsc_pkg::dtok_t tok_nxt;
  logic            en;

  function automatic upsc_pkg::lane_t step(input upsc_pkg::lane_t l);
    upsc_pkg::lane_t                o;
    logic [upsc_pkg::RemW-1:0]      r2;
    o = l;
    r2 = {l.rem[upsc_pkg::RemW-2:0], l.bits[upsc_pkg::QW-1]};
    o.bits = {l.bits[upsc_pkg::QW-2:0], 1'b0};
    if (r2 >= upsc_pkg::RemW'(l.div)) begin
      o.rem = r2 - upsc_pkg::RemW'(l.div);
      o.quo = {l.quo[upsc_pkg::QW-2:0], 1'b1};
    end else begin
      o.rem = r2;
      o.quo = {l.quo[upsc_pkg::QW-2:0], 1'b0};
    end
    return o;
  endfunction

  assign en     = !v_r || dn_rdy;
  assign up_rdy = en;
  assign dn_v   = v_r;
  assign dn_tok = tok_r;

  always_comb begin
    tok_nxt = up_tok;
    for (int s = 0; s < upsc_pkg::StepsPerStage; s++) begin
      tok_nxt.lx = step(tok_nxt.lx);
      tok_nxt.ly = step(tok_nxt.ly);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

/* sv/upsc_bank.sv */
module upsc_bank #(
  parameter int unsigned DEPTH = 1,
  parameter int unsigned AW    = 1
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [upsc_pkg::RgbW-1:0]  wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [upsc_pkg::RgbW-1:0]  rdata
);

  logic [upsc_pkg::RgbW-1:0] mem [DEPTH];
  logic [upsc_pkg::RgbW-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* sv/upsc_blend.sv */
module upsc_blend (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_v,
  output logic                       up_rdy,
  input  logic [upsc_pkg::RgbW-1:0]  p00,
  input  logic [upsc_pkg::RgbW-1:0]  p01,
  input  logic [upsc_pkg::RgbW-1:0]  p10,
  input  logic [upsc_pkg::RgbW-1:0]  p11,
  input  logic [upsc_pkg::FW-1:0]    fx,
  input  logic [upsc_pkg::FW-1:0]    fy,
  output logic                       dn_v,
  output logic [upsc_pkg::PixW-1:0]  dn_pixel,
  input  logic                       dn_rdy
);

  logic                      v_h_r;
  logic [upsc_pkg::RgbW-1:0] top_r;
  logic [upsc_pkg::RgbW-1:0] bot_r;
  logic [upsc_pkg::FW-1:0]   fy_r;
  logic                      v_o_r;
  logic [upsc_pkg::PixW-1:0] pix_r;
  logic                      en_h;
  logic                      en_o;

  assign en_o     = !v_o_r || dn_rdy;
  assign en_h     = !v_h_r || en_o;
  assign up_rdy   = en_h;
  assign dn_v     = v_o_r;
  assign dn_pixel = pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_h_r <= 1'b0;
      v_o_r <= 1'b0;
    end else begin
      if (en_h) v_h_r <= up_v;
      if (en_o) v_o_r <= v_h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_h) begin
      top_r <= upsc_pkg::blend_rgb(p00, p01, fx);
      bot_r <= upsc_pkg::blend_rgb(p10, p11, fx);
      fy_r  <= fy;
    end
    if (en_o) begin
      pix_r <= {upsc_pkg::AlphaOpaque, upsc_pkg::blend_rgb(top_r, bot_r, fy_r)};
    end
  end

endmodule

/* sv/bilinear_image_upscaler_core.sv */
// Bilinear upscaler: write beats (req_type 0) store one RGB source pixel, read beats
// (req_type 1) return one interpolated 0xFFRRGGBB pixel. Sustains one beat per clock
// while the output is not stalled. A 13-stage divider (two quotient bits per stage)
// maps the destination coordinate into 10.16 source space. Source storage is four
// banks split by row and column parity so all four neighbors are read in the same
// cycle. Writes stay in order with reads. Change dst_width/dst_height only while idle.
`include "bilinear_image_upscaler_core_defines.svh"

module bilinear_image_upscaler_core #(
  parameter int unsigned SRC_WIDTH  = 320,
  parameter int unsigned SRC_HEIGHT = 240
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_idx,
  input  logic [upsc_pkg::DimW-1:0]  cfg_data,
  upsc_in_if.sink                    in_if,
  upsc_out_if.source                 out_if
);

  localparam int unsigned SrcPixels = SRC_WIDTH * SRC_HEIGHT;
  localparam int unsigned HalfW     = (SRC_WIDTH + 1) / 2;
  localparam int unsigned HalfH     = (SRC_HEIGHT + 1) / 2;
  localparam int unsigned BankDepth = HalfW * HalfH;
  localparam int unsigned BankAw    = (BankDepth > 1) ? $clog2(BankDepth) : 1;
  localparam int unsigned RecipShift = 28;
  localparam int unsigned RecipW    = 28;
  localparam int unsigned ProdW     = upsc_pkg::IdxW + RecipW;
  localparam logic [RecipW-1:0] RecipM =
    RecipW'(((64'd1 << RecipShift) + 64'(SRC_WIDTH) - 64'd1) / 64'(SRC_WIDTH));
  localparam logic [upsc_pkg::QW-1:0] MaxPosX = upsc_pkg::QW'((SRC_WIDTH - 1) * 65536);
  localparam logic [upsc_pkg::QW-1:0] MaxPosY = upsc_pkg::QW'((SRC_HEIGHT - 1) * 65536);
  localparam int unsigned SW = upsc_pkg::SrcCoordW;

  // config
  logic [upsc_pkg::DimW-1:0] dst_w_r;
  logic [upsc_pkg::DimW-1:0] dst_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_w_r <= upsc_pkg::DstWidthRst;
      dst_h_r <= upsc_pkg::DstHeightRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        upsc_pkg::CFG_DST_WIDTH:  dst_w_r <= cfg_data;
        upsc_pkg::CFG_DST_HEIGHT: dst_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage A: numerators, divisors, write row reciprocal
  logic                       v_a_r, rd_a_r, ok_a_r;
  logic [upsc_pkg::NumW-1:0]  nx_a_r, ny_a_r;
  logic [upsc_pkg::DimW-1:0]  dvx_a_r, dvy_a_r;
  logic [ProdW-1:0]           prod_a_r;
  logic [upsc_pkg::IdxW-1:0]  idx_a_r;
  logic [upsc_pkg::RgbW-1:0]  pix_a_r;
  logic                       en_a, en_b, en_p, en_m;

  assign in_if.ready = en_a;
  assign en_a = !v_a_r || en_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
    end else if (en_a) begin
      v_a_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      rd_a_r   <= (in_if.req_type == upsc_pkg::REQ_READ);
      nx_a_r   <= upsc_pkg::NumW'({in_if.dst_x, 1'b1}) * upsc_pkg::NumW'(SRC_WIDTH);
      ny_a_r   <= upsc_pkg::NumW'({in_if.dst_y, 1'b1}) * upsc_pkg::NumW'(SRC_HEIGHT);
      dvx_a_r  <= (dst_w_r == '0) ? upsc_pkg::DimW'(1) : dst_w_r;
      dvy_a_r  <= (dst_h_r == '0) ? upsc_pkg::DimW'(1) : dst_h_r;
      prod_a_r <= ProdW'(in_if.src_index) * ProdW'(RecipM);
      idx_a_r  <= in_if.src_index;
      pix_a_r  <= in_if.src_pixel;
      ok_a_r   <= 32'(in_if.src_index) < 32'(SrcPixels);
    end
  end

  // stage B: divider setup, write coordinates
  logic            v_b_r;
  upsc_pkg::dtok_t tok_b_r;
  upsc_pkg::dtok_t tok_b_nxt;
  logic [upsc_pkg::IdxW-1:0] wy_full, wx_full;

  function automatic upsc_pkg::lane_t lane_init(input logic [upsc_pkg::NumW-1:0] n,
                                                input logic [upsc_pkg::DimW-1:0] dv);
    upsc_pkg::lane_t l;
    l.div  = dv;
    l.sat  = n >= {dv, upsc_pkg::QiW'(0)};
    l.rem  = l.sat ? '0 : upsc_pkg::RemW'(n[upsc_pkg::NumW-1:upsc_pkg::QiW]);
    l.quo  = '0;
    l.bits = {n[upsc_pkg::QiW-1:0], upsc_pkg::FracShift'(0)};
    return l;
  endfunction

  always_comb begin
    wy_full = prod_a_r[RecipShift +: upsc_pkg::IdxW];
    wx_full = idx_a_r - upsc_pkg::IdxW'(wy_full * upsc_pkg::IdxW'(SRC_WIDTH));
    tok_b_nxt.is_rd = rd_a_r;
    tok_b_nxt.lx    = lane_init(nx_a_r, dvx_a_r);
    tok_b_nxt.ly    = lane_init(ny_a_r, dvy_a_r);
    tok_b_nxt.wr_ok = ok_a_r;
    tok_b_nxt.wx    = wx_full[SW-1:0];
    tok_b_nxt.wy    = wy_full[SW-1:0];
    tok_b_nxt.pix   = pix_a_r;
  end

  logic                  div_v   [upsc_pkg::DivStages+1];
  logic                  div_rdy [upsc_pkg::DivStages+1];
  upsc_pkg::dtok_t       div_tok [upsc_pkg::DivStages+1];

  assign en_b = !v_b_r || div_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b_r <= 1'b0;
    end else if (en_b) begin
      v_b_r <= v_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      tok_b_r <= tok_b_nxt;
    end
  end

  // divider chain
  assign div_v[0]   = v_b_r;
  assign div_tok[0] = tok_b_r;
  assign div_rdy[upsc_pkg::DivStages] = en_p;

  for (genvar g = 0; g < upsc_pkg::DivStages; g++) begin : g_div
    upsc_div_stage u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .up_v   (div_v[g]),
      .up_tok (div_tok[g]),
      .up_rdy (div_rdy[g]),
      .dn_v   (div_v[g+1]),
      .dn_tok (div_tok[g+1]),
      .dn_rdy (div_rdy[g+1])
    );
  end

  // stage P: clamp, neighbors, bank addresses
  function automatic logic [upsc_pkg::QW-1:0] clamp_pos(input upsc_pkg::lane_t l,
                                                        input logic [upsc_pkg::QW-1:0] maxp);
    logic [upsc_pkg::QW-1:0] p;
    p = l.quo - upsc_pkg::HalfPos;
    if (l.sat) p = maxp;
    else if (l.quo < upsc_pkg::HalfPos) p = '0;
    else if (p > maxp) p = maxp;
    return p;
  endfunction

  function automatic logic [BankAw-1:0] bank_addr(input logic [SW-1:0] row,
                                                  input logic [SW-1:0] col);
    return BankAw'(32'(row >> 1) * 32'(HalfW) + 32'(col >> 1));
  endfunction

  upsc_pkg::dtok_t         tk_l;
  logic [upsc_pkg::QW-1:0] posx, posy;
  logic [SW-1:0]           x0, x1, y0, y1;
  logic [BankAw-1:0]       raddr_nxt [4];

  logic                      v_p_r, rd_p_r, ok_p_r;
  logic [BankAw-1:0]         raddr_p_r [4];
  logic [BankAw-1:0]         waddr_p_r;
  logic [1:0]                wbank_p_r;
  logic [upsc_pkg::RgbW-1:0] wpix_p_r;
  logic                      x0p_p_r, x1p_p_r, y0p_p_r, y1p_p_r;
  logic [SW-1:0]             x0_p_r, y0_p_r;
  logic [upsc_pkg::FW-1:0]   fx_p_r, fy_p_r;

  assign tk_l = div_tok[upsc_pkg::DivStages];

  always_comb begin
    posx = clamp_pos(tk_l.lx, MaxPosX);
    posy = clamp_pos(tk_l.ly, MaxPosY);
    x0 = posx[16 +: SW];
    y0 = posy[16 +: SW];
    x1 = (32'(x0) < SRC_WIDTH - 1)  ? x0 + SW'(1) : x0;
    y1 = (32'(y0) < SRC_HEIGHT - 1) ? y0 + SW'(1) : y0;
    for (int b = 0; b < 4; b++) begin
      raddr_nxt[b] = bank_addr((y0[0] == b[1]) ? y0 : y1, (x0[0] == b[0]) ? x0 : x1);
    end
  end

  assign en_p = !v_p_r || en_m;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_p_r <= 1'b0;
    end else if (en_p) begin
      v_p_r <= div_v[upsc_pkg::DivStages];
    end
  end

  always_ff @(posedge clk) begin
    if (en_p) begin
      rd_p_r    <= tk_l.is_rd;
      ok_p_r    <= tk_l.wr_ok;
      raddr_p_r <= raddr_nxt;
      waddr_p_r <= bank_addr(tk_l.wy, tk_l.wx);
      wbank_p_r <= {tk_l.wy[0], tk_l.wx[0]};
      wpix_p_r  <= tk_l.pix;
      x0p_p_r   <= x0[0];
      x1p_p_r   <= x1[0];
      y0p_p_r   <= y0[0];
      y1p_p_r   <= y1[0];
      x0_p_r    <= x0;
      y0_p_r    <= y0;
      fx_p_r    <= posx[15:8];
      fy_p_r    <= posy[15:8];
    end
  end

  // stage M: bank access
  logic                      v_m_r, rd_m_r;
  logic                      x0p_m_r, x1p_m_r, y0p_m_r, y1p_m_r;
  logic [upsc_pkg::FW-1:0]   fx_m_r, fy_m_r;
  logic [upsc_pkg::RgbW-1:0] rdata [4];
  logic [3:0]                bank_we;
  logic                      bank_re;
  logic                      blend_rdy;

  assign en_m    = !(v_m_r && rd_m_r) || blend_rdy;
  assign bank_re = en_m && v_p_r && rd_p_r;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    assign bank_we[b] = en_m && v_p_r && !rd_p_r && ok_p_r && (wbank_p_r == 2'(b));
    upsc_bank #(.DEPTH(BankDepth), .AW(BankAw)) u_bank (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (waddr_p_r),
      .wdata (wpix_p_r),
      .re    (bank_re),
      .raddr (raddr_p_r[b]),
      .rdata (rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_m_r <= 1'b0;
    end else if (en_m) begin
      v_m_r <= v_p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_m) begin
      rd_m_r  <= rd_p_r;
      x0p_m_r <= x0p_p_r;
      x1p_m_r <= x1p_p_r;
      y0p_m_r <= y0p_p_r;
      y1p_m_r <= y1p_p_r;
      fx_m_r  <= fx_p_r;
      fy_m_r  <= fy_p_r;
    end
  end

  // blend
  upsc_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_v     (v_m_r && rd_m_r),
    .up_rdy   (blend_rdy),
    .p00      (rdata[{y0p_m_r, x0p_m_r}]),
    .p01      (rdata[{y0p_m_r, x1p_m_r}]),
    .p10      (rdata[{y1p_m_r, x0p_m_r}]),
    .p11      (rdata[{y1p_m_r, x1p_m_r}]),
    .fx       (fx_m_r),
    .fy       (fy_m_r),
    .dn_v     (out_if.valid),
    .dn_pixel (out_if.out_pixel),
    .dn_rdy   (out_if.ready)
  );

  `UPSC_ASSERT_NOW(a_div_rem, div_v[upsc_pkg::DivStages] && tk_l.is_rd, (tk_l.lx.rem < upsc_pkg::RemW'(tk_l.lx.div)) && (tk_l.ly.rem < upsc_pkg::RemW'(tk_l.ly.div)))
  `UPSC_ASSERT_NOW(a_pos_in_img, v_p_r && rd_p_r, (32'(x0_p_r) < SRC_WIDTH) && (32'(y0_p_r) < SRC_HEIGHT))
  `UPSC_ASSERT_NOW(a_edge_frac, v_p_r && rd_p_r && (32'(x0_p_r) == SRC_WIDTH - 1), fx_p_r == '0)
  `UPSC_ASSERT_NOW(a_bank_port, |bank_we, !bank_re && $onehot(bank_we))
  `UPSC_ASSERT_NEXT(a_m_hold, v_m_r && rd_m_r && !blend_rdy, v_m_r && rd_m_r && $stable(fx_m_r) && $stable(fy_m_r))

endmodule
